// ===== rtl/anxb_pkg.sv =====
// shared types, constants and helpers for the annex b nal splitter
// used by anxb_parser, anxb_rsp_fifo and annexb_nal_splitter
// no dependencies
package anxb_pkg;

   localparam int RSP_DEPTH      = 8;
   localparam int RSP_PTR_W      = $clog2(RSP_DEPTH);
   localparam int RSP_LVL_W      = $clog2(RSP_DEPTH + 1);
   localparam int MAX_PUSH       = 4;
   localparam int PUSH_CNT_W     = $clog2(MAX_PUSH + 1);
   localparam int STEP_MAX_LEVEL = RSP_DEPTH - MAX_PUSH;

   // scan phases
   localparam logic [1:0] PH_LEAD = 2'd0;
   localparam logic [1:0] PH_BODY = 2'd1;
   localparam logic [1:0] PH_SKIP = 2'd2;
   localparam logic [1:0] PH_WAIT = 2'd3;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       first_of_nal;
      logic       last_of_nal;
      logic       empty_nal;
      logic       forbidden_bit;
      logic [1:0] ref_idc;
      logic [4:0] unit_type;
   } res_type;

   typedef struct packed {
      logic [PUSH_CNT_W-1:0]      count;
      res_type [MAX_PUSH-1:0]     item;
   } push_type;

   function automatic res_type make_res(input logic [7:0] pb, input logic is_first,
                                        input logic is_last, input logic is_empty,
                                        input logic [7:0] hdr);
      res_type r;
      r.payload_byte  = pb;
      r.first_of_nal  = is_first;
      r.last_of_nal   = is_last;
      r.empty_nal     = is_empty;
      r.forbidden_bit = hdr[7];
      r.ref_idc       = hdr[6:5];
      r.unit_type     = hdr[4:0];
      return r;
   endfunction

endpackage

// ===== rtl/annexb_nal_splitter.sv =====
// annex b nal splitter top level: input register, parser, result queue
// an accepted byte is held in the input register, then the parser writes its results into the result queue
// throughput: one byte per cycle; one result per cycle while rsp_stall is low, out of an eight-entry queue,
// input stalls while the queue holds more than four results
// reset: synchronous, clears the scanner to leading start code search and empties the queue
// depends on anxb_pkg, anxb_parser, anxb_rsp_fifo
module annexb_nal_splitter
   import anxb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_first_of_nal,
   output logic       rsp_last_of_nal,
   output logic       rsp_empty_nal,
   output logic       rsp_forbidden_bit,
   output logic [1:0] rsp_ref_idc,
   output logic [4:0] rsp_unit_type
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 in_last_ff;
   logic                 step_fire;
   logic                 pop;
   push_type             push;
   res_type              head;
   logic [RSP_LVL_W-1:0] level;

   assign step_fire   = in_valid_ff && (level <= RSP_LVL_W'(STEP_MAX_LEVEL));
   assign req_stall   = in_valid_ff && !step_fire;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   anxb_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_fire (step_fire),
      .step_byte (in_byte_ff),
      .step_last (in_last_ff),
      .push      (push)
   );

   anxb_rsp_fifo u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .level (level)
   );

   assign rsp_valid         = (level != '0);
   assign pop               = rsp_valid && !rsp_stall;
   assign rsp_payload_byte  = head.payload_byte;
   assign rsp_first_of_nal  = head.first_of_nal;
   assign rsp_last_of_nal   = head.last_of_nal;
   assign rsp_empty_nal     = head.empty_nal;
   assign rsp_forbidden_bit = head.forbidden_bit;
   assign rsp_ref_idc       = head.ref_idc;
   assign rsp_unit_type     = head.unit_type;

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= RSP_LVL_W'(RSP_DEPTH))
      else $error("result queue overflow");

   a_level_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> level == $past(level) + RSP_LVL_W'($past(push.count))
                                 - RSP_LVL_W'($past(pop)))
      else $error("result queue level out of step with transfers");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
      else $error("stalled input byte lost");

   a_no_push_idle: assert property (@(posedge clock) disable iff (reset)
      !step_fire |-> push.count == '0)
      else $error("results pushed without a step");

endmodule

// ===== rtl/anxb_parser.sv =====
// start code scanner and nal header unpacker, one byte per step
// holds the scan state and the overflow result; depends on anxb_pkg
module anxb_parser
   import anxb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_fire,
   input  logic [7:0] step_byte,
   input  logic       step_last,
   output push_type   push
);

   logic [1:0]  phase_ff, phase_in;
   logic [23:0] window_ff, window_in;
   logic [1:0]  fill_ff, fill_in;
   logic [7:0]  header_ff, header_in;
   logic        first_ff, first_in;
   logic [1:0]  prefix_ff, prefix_in;
   logic [7:0]  held_ff, held_in;
   logic        spill_valid_ff, spill_valid_in;
   res_type     spill_ff, spill_in;

   res_type     slot [0:4];
   logic [2:0]  n;
   logic [7:0]  a0, a1, a2;
   logic        three, four;
   logic [7:0]  lb [0:3];
   logic [2:0]  ln;
   logic [1:0]  idx;
   logic        start;

   assign a0    = window_ff[23:16];
   assign a1    = window_ff[15:8];
   assign a2    = window_ff[7:0];
   assign three = (a0 == 8'h00) && (a1 == 8'h00) && (a2 == 8'h01);
   assign four  = (a0 == 8'h00) && (a1 == 8'h00) && (a2 == 8'h00) && (step_byte == 8'h01);

   always_comb begin
      phase_in  = phase_ff;
      window_in = window_ff;
      fill_in   = fill_ff;
      header_in = header_ff;
      first_in  = first_ff;
      prefix_in = prefix_ff;
      held_in   = held_ff;
      n         = '0;
      ln        = '0;
      idx       = '0;
      start     = 1'b0;
      for (int i = 0; i < 5; i++) slot[i] = '0;
      for (int i = 0; i < 4; i++) lb[i] = '0;

      if (spill_valid_ff) begin
         slot[0] = spill_ff;
         n       = 3'd1;
      end

      case (phase_ff)
         PH_LEAD: begin
            if (fill_ff != 2'd3) begin
               window_in = {window_ff[15:0], step_byte};
               fill_in   = fill_ff + 2'd1;
            end else if (window_ff == 24'h000001) begin
               phase_in  = PH_BODY;
               header_in = step_byte;
               window_in = {16'h0000, step_byte};
               fill_in   = 2'd1;
               prefix_in = 2'd0;
               first_in  = 1'b1;
               held_in   = 8'h00;
            end else if (window_ff == 24'h000000 && step_byte == 8'h01) begin
               phase_in  = PH_WAIT;
               window_in = '0;
               fill_in   = '0;
            end else begin
               phase_in = PH_SKIP;
            end
         end
         PH_BODY: begin
            if (fill_ff == 2'd3) begin
               if (three || four) begin
                  // close the current unit
                  if (prefix_ff[1]) begin
                     slot[n]  = make_res(held_ff, first_in, 1'b1, 1'b0, header_ff);
                     n        = n + 3'd1;
                     first_in = 1'b0;
                  end else if (prefix_ff == 2'd1) begin
                     slot[n]  = make_res(8'h00, 1'b1, 1'b1, 1'b1, header_ff);
                     n        = n + 3'd1;
                     first_in = 1'b0;
                  end
                  if (three) begin
                     phase_in  = PH_BODY;
                     header_in = step_byte;
                     window_in = {16'h0000, step_byte};
                     fill_in   = 2'd1;
                     prefix_in = 2'd0;
                     first_in  = 1'b1;
                     held_in   = 8'h00;
                  end else begin
                     phase_in  = PH_WAIT;
                     window_in = '0;
                     fill_in   = '0;
                  end
               end else begin
                  if (prefix_ff == 2'd0) begin
                     prefix_in = 2'd1;
                  end else if (prefix_ff == 2'd1) begin
                     held_in   = a0;
                     prefix_in = 2'd2;
                  end else begin
                     slot[n]   = make_res(held_ff, first_in, 1'b0, 1'b0, header_ff);
                     n         = n + 3'd1;
                     first_in  = 1'b0;
                     held_in   = a0;
                     prefix_in = 2'd2;
                  end
                  window_in = {a1, a2, step_byte};
                  fill_in   = 2'd3;
               end
            end else begin
               window_in = {window_ff[15:0], step_byte};
               fill_in   = fill_ff + 2'd1;
            end
         end
         PH_WAIT: begin
            phase_in  = PH_BODY;
            header_in = step_byte;
            window_in = {16'h0000, step_byte};
            fill_in   = 2'd1;
            prefix_in = 2'd0;
            first_in  = 1'b1;
            held_in   = 8'h00;
         end
         default: begin
         end
      endcase

      if (step_last) begin
         if (phase_in == PH_BODY) begin
            // end of buffer inside a unit: all pending bytes are payload
            start = (prefix_in == 2'd0);
            if (prefix_in[1]) begin
               lb[0] = held_in;
               ln    = 3'd1;
            end
            for (int i = 0; i < 3; i++) begin
               if ((i >= int'(start)) && (i < int'(fill_in))) begin
                  idx       = fill_in - 2'(i) - 2'd1;
                  lb[ln[1:0]] = window_in[{idx, 3'b000} +: 8];
                  ln        = ln + 3'd1;
               end
            end
            if (ln == 3'd0) begin
               slot[n]  = make_res(8'h00, 1'b1, 1'b1, 1'b1, header_in);
               n        = n + 3'd1;
               first_in = 1'b0;
            end else begin
               for (int j = 0; j < 4; j++) begin
                  if (j < int'(ln)) begin
                     slot[n]  = make_res(lb[j], first_in, (j == int'(ln) - 1), 1'b0,
                                         header_in);
                     n        = n + 3'd1;
                     first_in = 1'b0;
                  end
               end
            end
         end
         phase_in  = PH_LEAD;
         window_in = '0;
         fill_in   = '0;
         header_in = '0;
         first_in  = 1'b1;
         prefix_in = '0;
         held_in   = '0;
      end
   end

   always_comb begin
      push.count = step_fire ? ((n > 3'd4) ? PUSH_CNT_W'(MAX_PUSH) : n) : '0;
      for (int j = 0; j < MAX_PUSH; j++) push.item[j] = slot[j];
      spill_valid_in = step_fire ? (n == 3'd5) : spill_valid_ff;
      spill_in       = step_fire ? slot[4] : spill_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_LEAD;
         window_ff      <= '0;
         fill_ff        <= '0;
         header_ff      <= '0;
         first_ff       <= 1'b1;
         prefix_ff      <= '0;
         held_ff        <= '0;
         spill_valid_ff <= 1'b0;
      end else if (step_fire) begin
         phase_ff       <= phase_in;
         window_ff      <= window_in;
         fill_ff        <= fill_in;
         header_ff      <= header_in;
         first_ff       <= first_in;
         prefix_ff      <= prefix_in;
         held_ff        <= held_in;
         spill_valid_ff <= spill_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      spill_ff <= spill_in;
   end

endmodule

// ===== rtl/anxb_rsp_fifo.sv =====
// result queue, up to four writes per cycle and one read at the head
// depends on anxb_pkg
module anxb_rsp_fifo
   import anxb_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  push_type             push,
   input  logic                 pop,
   output res_type              head,
   output logic [RSP_LVL_W-1:0] level
);

   res_type                mem_ff [0:RSP_DEPTH-1];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_LVL_W-1:0]   level_ff, level_in;

   assign head  = mem_ff[rd_ptr_ff];
   assign level = level_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      level_in  = level_ff + RSP_LVL_W'(push.count) - RSP_LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_PUSH; i++) begin
         if (i < int'(push.count)) begin
            mem_ff[wr_ptr_ff + RSP_PTR_W'(i)] <= push.item[i];
         end
      end
   end

endmodule

// ===== test/annexb_nal_splitter_check.sv =====
// transfer monitor, result predictor and scoreboard for annexb_nal_splitter
// depends on anxb_pkg; instantiated beside the dut by annexb_nal_splitter_test
`timescale 1ns / 100ps
module annexb_nal_splitter_check
   import anxb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_payload_byte,
   input  logic       rsp_first_of_nal,
   input  logic       rsp_last_of_nal,
   input  logic       rsp_empty_nal,
   input  logic       rsp_forbidden_bit,
   input  logic [1:0] rsp_ref_idc,
   input  logic [4:0] rsp_unit_type,
   output int         mismatches,
   output int         pending,
   output int         checked
);

   res_type     nal_out_q[$];
   res_type     step_out[8];
   int          step_n;
   int          err_cnt = 0;
   int          seen = 0;

   logic [23:0] win;
   logic [1:0]  win_fill;
   logic [1:0]  scan_st;
   logic [7:0]  hdr;
   logic        first_due;
   logic [2:0]  prefix_cnt;
   logic [7:0]  held;
   logic        spill_held;
   res_type     spill_res;

   initial begin
      mismatches = 0;
      pending = 0;
      checked = 0;
   end

   task automatic add_res(input logic [7:0] pb, input logic fst, input logic lst,
                          input logic emp);
      res_type r;
      if (step_n < 8) begin
         r.payload_byte  = pb;
         r.first_of_nal  = fst;
         r.last_of_nal   = lst;
         r.empty_nal     = emp;
         r.forbidden_bit = hdr[7];
         r.ref_idc       = hdr[6:5];
         r.unit_type     = hdr[4:0];
         step_out[step_n] = r;
         step_n++;
      end
   endtask

   task automatic add_payload(input logic [7:0] b, input logic lst);
      add_res(b, first_due, lst, 1'b0);
      first_due = 1'b0;
   endtask

   task automatic add_empty();
      add_res(8'h00, 1'b1, 1'b1, 1'b1);
      first_due = 1'b0;
   endtask

   task automatic restart_scan();
      scan_st    = PH_LEAD;
      win        = '0;
      win_fill   = '0;
      hdr        = '0;
      first_due  = 1'b1;
      prefix_cnt = '0;
      held       = '0;
   endtask

   task automatic await_header();
      scan_st  = PH_WAIT;
      win      = '0;
      win_fill = '0;
   endtask

   task automatic open_nal(input logic [7:0] h);
      scan_st    = PH_BODY;
      hdr        = h;
      win        = {16'h0000, h};
      win_fill   = 2'd1;
      prefix_cnt = '0;
      first_due  = 1'b1;
      held       = '0;
   endtask

   // buffer ended inside a unit: all unresolved bytes are payload
   task automatic flush_nal();
      logic [7:0] tail[4];
      int n;
      int f;
      int lo;
      n = 0;
      f = win_fill;
      lo = (prefix_cnt == 0) ? 1 : 0;
      if (prefix_cnt >= 2) begin
         tail[n] = held;
         n++;
      end
      for (int i = lo; i < f; i++) begin
         tail[n] = win[8*(f-1-i) +: 8];
         n++;
      end
      if (n == 0) begin
         add_empty();
      end else begin
         for (int i = 0; i < n; i++) add_payload(tail[i], i == n - 1);
      end
      restart_scan();
   endtask

   task automatic close_nal();
      if (prefix_cnt >= 2) add_payload(held, 1'b1);
      else if (prefix_cnt == 1) add_empty();
   endtask

   task automatic scan_body(input logic [7:0] b, input logic lst);
      logic [7:0] w[4];
      int k;
      logic zz;
      logic three;
      logic four;
      k = win_fill;
      for (int i = 0; i < k; i++) w[i] = win[8*(k-1-i) +: 8];
      w[k] = b;
      k++;
      if (k == 4) begin
         zz    = (w[0] == 8'h00) && (w[1] == 8'h00);
         three = zz && (w[2] == 8'h01);
         four  = zz && (w[2] == 8'h00) && (w[3] == 8'h01);
         if (three || four) begin
            close_nal();
            if (three) begin
               open_nal(w[3]);
               if (lst) flush_nal();
            end else if (lst) begin
               restart_scan();
            end else begin
               await_header();
            end
            return;
         end
         if (prefix_cnt == 0) begin
            prefix_cnt = 3'd1;
         end else if (prefix_cnt == 1) begin
            held = w[0];
            prefix_cnt = 3'd2;
         end else begin
            add_payload(held, 1'b0);
            held = w[0];
            prefix_cnt = 3'd2;
         end
         w[0] = w[1];
         w[1] = w[2];
         w[2] = w[3];
         k = 3;
      end
      win = '0;
      for (int i = 0; i < k; i++) win = {win[15:0], w[i]};
      win_fill = k[1:0];
      if (lst) flush_nal();
   endtask

   task automatic scan_lead(input logic [7:0] b, input logic lst);
      if (win_fill < 2'd3) begin
         win = {win[15:0], b};
         win_fill = win_fill + 2'd1;
         if (lst) restart_scan();
      end else if (win == 24'h000001) begin
         open_nal(b);
         if (lst) flush_nal();
      end else if (win == 24'h000000 && b == 8'h01) begin
         if (lst) restart_scan();
         else await_header();
      end else if (lst) begin
         restart_scan();
      end else begin
         scan_st = PH_SKIP;
      end
   endtask

   // one accepted byte: queue the results it releases, keep a fifth for later
   task automatic predict_nal(input logic [7:0] b, input logic lst);
      step_n = 0;
      if (spill_held) begin
         step_out[0] = spill_res;
         step_n = 1;
         spill_held = 1'b0;
      end
      case (scan_st)
         PH_LEAD: scan_lead(b, lst);
         PH_BODY: scan_body(b, lst);
         PH_WAIT: begin
            open_nal(b);
            if (lst) flush_nal();
         end
         default: begin
            if (lst) restart_scan();
         end
      endcase
      for (int i = 0; i < step_n && i < MAX_PUSH; i++)
         nal_out_q.insert(nal_out_q.size(), step_out[i]);
      if (step_n > MAX_PUSH) begin
         spill_res = step_out[MAX_PUSH];
         spill_held = 1'b1;
      end
   endtask

   task automatic report(input string field, input int unsigned want, input int unsigned got);
      if (want != got) begin
         if (err_cnt < 100)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
         err_cnt++;
      end
   endtask

   always @(posedge clock) begin
      res_type got;
      res_type want;
      if (reset) begin
         restart_scan();
         spill_held = 1'b0;
         nal_out_q.delete();
      end else begin
         if (req_valid && !req_stall) predict_nal(req_data_byte, req_last_byte);
         if (rsp_valid && !rsp_stall) begin
            got.payload_byte  = rsp_payload_byte;
            got.first_of_nal  = rsp_first_of_nal;
            got.last_of_nal   = rsp_last_of_nal;
            got.empty_nal     = rsp_empty_nal;
            got.forbidden_bit = rsp_forbidden_bit;
            got.ref_idc       = rsp_ref_idc;
            got.unit_type     = rsp_unit_type;
            seen++;
            if (nal_out_q.size() == 0) begin
               if (err_cnt < 100)
                  $display("%0t: unexpected transfer, expected none, got %h", $time, got);
               err_cnt++;
            end else begin
               want = nal_out_q.pop_front();
               report("payload_byte", want.payload_byte, got.payload_byte);
               report("first_of_nal", want.first_of_nal, got.first_of_nal);
               report("last_of_nal", want.last_of_nal, got.last_of_nal);
               report("empty_nal", want.empty_nal, got.empty_nal);
               report("forbidden_bit", want.forbidden_bit, got.forbidden_bit);
               report("ref_idc", want.ref_idc, got.ref_idc);
               report("unit_type", want.unit_type, got.unit_type);
            end
         end
      end
      mismatches <= err_cnt;
      pending    <= nal_out_q.size();
      checked    <= seen;
   end

endmodule

// ===== test/annexb_nal_splitter_test.sv =====
// top of the annexb_nal_splitter testbench: clock, reset, byte stream stimulus, verdict
// depends on annexb_nal_splitter and annexb_nal_splitter_check
`timescale 1ns / 100ps
module annexb_nal_splitter_test;

   localparam int IDLE_LIMIT  = 2000;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_BYTES = 140;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_payload_byte;
   logic       rsp_first_of_nal;
   logic       rsp_last_of_nal;
   logic       rsp_empty_nal;
   logic       rsp_forbidden_bit;
   logic [1:0] rsp_ref_idc;
   logic [4:0] rsp_unit_type;

   int         mismatches;
   int         pending;
   int         checked;

   int         tx_idle_pct = 15;
   int         rx_idle_pct = 79;
   logic       hold_req = 1'b0;
   int         hold_cnt = 0;
   int         quiet = 0;
   int         n_bytes = 0;
   int         n_frames = 0;
   logic [7:0] frame[$];

   annexb_nal_splitter DUT (.*);

   annexb_nal_splitter_check CHK (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
         rsp_stall <= 1'b1;
         hold_cnt <= hold_cnt + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic lst);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= lst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n_bytes++;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
      frame.delete();
      n_frames++;
   endtask

   task automatic wait_drained();
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic add_octet(input logic [7:0] b);
      frame.insert(frame.size(), b);
   endtask

   // zero-heavy bytes so that start codes show up inside payloads
   function automatic logic [7:0] rand_octet();
      int r;
      r = $urandom_range(9);
      if (r < 3) return 8'h00;
      if (r == 3) return 8'h01;
      return 8'($urandom_range(255));
   endfunction

   task automatic push_start_code();
      if ($urandom_range(1)) add_octet(8'h00);
      add_octet(8'h00);
      add_octet(8'h00);
      add_octet(8'h01);
   endtask

   task automatic build_frame();
      int kind;
      int units;
      int len;
      kind = $urandom_range(9);
      if (kind == 0) begin
         len = $urandom_range(1, 8);
         repeat (len) add_octet(rand_octet());
      end else if (kind == 1) begin
         push_start_code();
         if ($urandom_range(1)) add_octet(8'($urandom_range(255)));
      end else begin
         units = $urandom_range(1, 3);
         repeat (units) begin
            push_start_code();
            add_octet(($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(255)));
            len = $urandom_range(0, 6);
            repeat (len) add_octet(rand_octet());
         end
         if (kind == 2) frame[0] = 8'($urandom_range(1, 255));
      end
   endtask

   task automatic random_phase();
      int base;
      base = n_bytes;
      while (n_bytes - base < PHASE_BYTES) begin
         build_frame();
         send_frame();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // header only unit closed by a long start code at the very end
      frame = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hE5, 8'h00, 8'h00, 8'h00, 8'h01};
      send_frame();
      // start code in the header slot, then five bytes resolved by the last byte
      frame = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h61, 8'hFF, 8'h80,
                8'h00, 8'h7F, 8'h01};
      send_frame();
      // no start code at the head
      frame = '{8'h7E, 8'h00, 8'h00, 8'h01, 8'h67};
      send_frame();

      random_phase();
      req_valid <= 1'b0;
      wait_drained();

      tx_idle_pct = 79;
      rx_idle_pct <= 15;
      random_phase();

      tx_idle_pct = 0;
      rx_idle_pct <= 0;
      hold_req <= 1'b1;
      random_phase();

      // lone byte pushes out any result still held back
      frame = '{8'h00};
      send_frame();
      req_valid <= 1'b0;

      wait_drained();
      repeat (10) @(posedge clock);
      $display("run covered %0d bytes in %0d buffers, %0d results compared", n_bytes,
               n_frames, checked);
      $display("three sender/receiver idle mixes plus a long receiver hold-off");
      if (mismatches == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d results never arrived", mismatches, pending);
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/anxb_pkg.sv
rtl/anxb_parser.sv
rtl/anxb_rsp_fifo.sv
rtl/annexb_nal_splitter.sv
test/annexb_nal_splitter_check.sv
test/annexb_nal_splitter_test.sv
